@@ rtl/mcrs_pkg.sv @@
package mcrs_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CNT_W      = 21;
  localparam int unsigned SUM_W      = 29;
  localparam int unsigned SQ_W       = 37;
  localparam int unsigned FIDX_W     = 4;
  localparam int unsigned FVAL_W     = 24;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned MAX_PIXELS = 1048576;
  localparam int unsigned HUE_BINS   = 180;
  localparam int unsigned HIST_AW    = 8;

  // long division: 90 dividend bits, one per cycle
  localparam int unsigned DIV_DVD_W  = 90;
  localparam int unsigned DIV_DSR_W  = 41;
  localparam int unsigned DIV_Q_W    = 48;
  localparam int unsigned DIV_CNT_W  = 7;
  localparam int unsigned DIV_STEPS  = 90;

  // integer square root: two radicand bits per cycle
  localparam int unsigned SQ_IN_W    = 48;
  localparam int unsigned SQ_OUT_W   = 24;
  localparam int unsigned SQ_REM_W   = 26;
  localparam int unsigned SQ_CNT_W   = 5;
  localparam int unsigned SQ_STEPS   = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_BROWN_LO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BROWN_HI  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GOLDEN_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GOLDEN_HI = 2'd3;

  localparam logic [PIX_W-1:0] BROWN_LO_RST  = 8'd5;
  localparam logic [PIX_W-1:0] BROWN_HI_RST  = 8'd25;
  localparam logic [PIX_W-1:0] GOLDEN_LO_RST = 8'd15;
  localparam logic [PIX_W-1:0] GOLDEN_HI_RST = 8'd35;

  typedef struct packed {
    logic                 start;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               start;
    logic [SQ_IN_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

@@ rtl/mcrs_if.sv @@
interface mcrs_pix_if;
  import mcrs_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] hue;
  logic [PIX_W-1:0] saturation;
  logic [PIX_W-1:0] brightness;
  logic [PIX_W-1:0] lightness;
  logic [PIX_W-1:0] green_red;
  logic [PIX_W-1:0] blue_yellow;
  logic             in_mask;
  logic             last_pixel;

  modport source (output valid, hue, saturation, brightness, lightness, green_red,
                  blue_yellow, in_mask, last_pixel, input ready);
  modport sink   (input valid, hue, saturation, brightness, lightness, green_red,
                  blue_yellow, in_mask, last_pixel, output ready);
endinterface

interface mcrs_res_if;
  import mcrs_pkg::*;

  logic              valid;
  logic              ready;
  logic [FIDX_W-1:0] feature_index;
  logic [FVAL_W-1:0] feature_value;
  logic              last_feature;

  modport source (output valid, feature_index, feature_value, last_feature, input ready);
  modport sink   (input valid, feature_index, feature_value, last_feature, output ready);
endinterface

@@ rtl/mcrs_ram.sv @@
module mcrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/mcrs_div.sv @@
module mcrs_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mcrs_pkg::div_req_t            req_i,
  output mcrs_pkg::unit_sts_t           sts_o,
  output logic [mcrs_pkg::DIV_Q_W-1:0]  quotient_o
);
  import mcrs_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_DVD_W-1:0] dvd_q;
  logic [DIV_DSR_W-1:0] dsr_q;
  logic [DIV_DSR_W-1:0] rem_q;
  logic [DIV_Q_W-1:0]   quo_q;

  logic [DIV_DSR_W:0]   trial;
  logic [DIV_DSR_W:0]   diff;
  logic                 ge;

  assign trial = {rem_q, dvd_q[DIV_DVD_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DIV_DVD_W-2:0], 1'b0};
      rem_q <= ge ? diff[DIV_DSR_W-1:0] : trial[DIV_DSR_W-1:0];
      quo_q <= {quo_q[DIV_Q_W-2:0], ge};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/mcrs_sqrt.sv @@
module mcrs_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mcrs_pkg::sqrt_req_t           req_i,
  output mcrs_pkg::unit_sts_t           sts_o,
  output logic [mcrs_pkg::SQ_OUT_W-1:0] root_o
);
  import mcrs_pkg::*;

  logic                busy_q, done_q;
  logic [SQ_CNT_W-1:0] cnt_q;
  logic [SQ_IN_W-1:0]  rad_q;
  logic [SQ_REM_W-1:0] rem_q;
  logic [SQ_OUT_W-1:0] root_q;

  logic [SQ_REM_W+1:0] cur;
  logic [SQ_REM_W+1:0] trial;
  logic [SQ_REM_W+1:0] diff;
  logic                ge;

  assign cur   = {rem_q, rad_q[SQ_IN_W-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = cur >= trial;
  assign diff  = cur - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == SQ_CNT_W'(SQ_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rad_q  <= req_i.radicand;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[SQ_IN_W-3:0], 2'b00};
      rem_q  <= ge ? diff[SQ_REM_W-1:0] : cur[SQ_REM_W-1:0];
      root_q <= {root_q[SQ_OUT_W-2:0], ge};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign root_o     = root_q;

endmodule

@@ rtl/masked_color_region_stats_top.sv @@
// Masked region color statistics. After reset the hue histogram RAM is zeroed in a
// clearing pass during which no pixel is taken. A pixel outside the mask (or past the
// 2^20-pixel frame limit) is handled in the idle state unless it is the last; a masked
// pixel also uses the shared 32x32 multiplier, forming the three squares one per cycle,
// and the histogram read-modify-write. The last pixel of a frame starts the report: a
// sweep of the histogram RAM (argmax and clear), then 15 results in feature order, each
// division done in the bit-serial divider and each standard deviation formed by
// multiplier steps, the divider, then the 24-step square root. Results leave through an
// output register; the next pixel is taken once the last result is loaded into it.
module masked_color_region_stats_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  mcrs_pix_if.sink                          pix_i,
  mcrs_res_if.source                        res_o,
  input  logic                              cfg_we_i,
  input  logic [mcrs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mcrs_pkg::PIX_W-1:0]        cfg_data_i
);
  import mcrs_pkg::*;

  localparam int unsigned ST_W = 4;
  localparam logic [ST_W-1:0] S_CLR   = 4'd0;
  localparam logic [ST_W-1:0] S_IDLE  = 4'd1;
  localparam logic [ST_W-1:0] S_PIX   = 4'd2;
  localparam logic [ST_W-1:0] S_SWEEP = 4'd3;
  localparam logic [ST_W-1:0] S_FEAT  = 4'd4;
  localparam logic [ST_W-1:0] S_MUL0  = 4'd5;
  localparam logic [ST_W-1:0] S_MUL1  = 4'd6;
  localparam logic [ST_W-1:0] S_MUL2  = 4'd7;
  localparam logic [ST_W-1:0] S_MUL3  = 4'd8;
  localparam logic [ST_W-1:0] S_MUL4  = 4'd9;
  localparam logic [ST_W-1:0] S_DIV   = 4'd10;
  localparam logic [ST_W-1:0] S_SQRT  = 4'd11;
  localparam logic [ST_W-1:0] S_EMIT  = 4'd12;

  localparam logic [FIDX_W-1:0] FEAT_AREA    = 4'd0;
  localparam logic [FIDX_W-1:0] FEAT_H_MEAN  = 4'd1;
  localparam logic [FIDX_W-1:0] FEAT_S_MEAN  = 4'd2;
  localparam logic [FIDX_W-1:0] FEAT_V_MEAN  = 4'd3;
  localparam logic [FIDX_W-1:0] FEAT_H_STD   = 4'd4;
  localparam logic [FIDX_W-1:0] FEAT_S_STD   = 4'd5;
  localparam logic [FIDX_W-1:0] FEAT_V_STD   = 4'd6;
  localparam logic [FIDX_W-1:0] FEAT_L_MEAN  = 4'd7;
  localparam logic [FIDX_W-1:0] FEAT_A_MEAN  = 4'd8;
  localparam logic [FIDX_W-1:0] FEAT_B_MEAN  = 4'd9;
  localparam logic [FIDX_W-1:0] FEAT_DOM_HUE = 4'd10;
  localparam logic [FIDX_W-1:0] FEAT_S_AGAIN = 4'd11;
  localparam logic [FIDX_W-1:0] FEAT_V_AGAIN = 4'd12;
  localparam logic [FIDX_W-1:0] FEAT_BAND0   = 4'd13;
  localparam logic [FIDX_W-1:0] FEAT_BAND1   = 4'd14;

  localparam int unsigned ACC_W = 58;

  // configuration
  logic [PIX_W-1:0] brown_lo_q, brown_hi_q, golden_lo_q, golden_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brown_lo_q  <= BROWN_LO_RST;
      brown_hi_q  <= BROWN_HI_RST;
      golden_lo_q <= GOLDEN_LO_RST;
      golden_hi_q <= GOLDEN_HI_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BROWN_LO:  brown_lo_q  <= cfg_data_i;
        CFG_BROWN_HI:  brown_hi_q  <= cfg_data_i;
        CFG_GOLDEN_LO: golden_lo_q <= cfg_data_i;
        CFG_GOLDEN_HI: golden_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [ST_W-1:0]    state_q;
  logic [CNT_W-1:0]   total_q, masked_q;
  logic [SUM_W-1:0]   sum_q [6];
  logic [SQ_W-1:0]    sq_q [3];
  logic [CNT_W-1:0]   band_q [2];
  logic [PIX_W-1:0]   pix_q [6];
  logic               acc_q, last_q;
  logic [1:0]         pcnt_q, ch_q;
  logic [HIST_AW-1:0] bin_q, sw_q, best_idx_q;
  logic [CNT_W-1:0]   best_cnt_q;
  logic [FIDX_W-1:0]  feat_q;
  logic               std_q;
  logic [FVAL_W-1:0]  val_q, mean_s_q, mean_v_q;
  logic [63:0]        mul_q;
  logic [ACC_W-1:0]   acc_sum_q, num_q;
  logic               out_valid_q, out_last_q;
  logic [FIDX_W-1:0]  out_idx_q;
  logic [FVAL_W-1:0]  out_val_q;

  logic               accept, under_lim, slot_free, is_ratio;
  logic [PIX_W-1:0]   bin_in;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [SUM_W-1:0]   rnum;
  logic [CNT_W-1:0]   rden;

  logic               ram_we;
  logic [HIST_AW-1:0] ram_waddr, ram_raddr;
  logic [CNT_W-1:0]   ram_wdata, ram_rdata;

  div_req_t           div_req;
  unit_sts_t          div_sts;
  logic [DIV_Q_W-1:0] div_quo;
  sqrt_req_t          sq_req;
  unit_sts_t          sq_sts;
  logic [SQ_OUT_W-1:0] sq_root;

  assign pix_i.ready = (state_q == S_IDLE);
  assign accept      = pix_i.valid && pix_i.ready;
  assign under_lim   = total_q < CNT_W'(MAX_PIXELS);
  assign bin_in      = (pix_i.hue < PIX_W'(HUE_BINS - 1)) ? pix_i.hue : PIX_W'(HUE_BINS - 1);
  assign slot_free   = !out_valid_q || res_o.ready;

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_PIX: begin
        mul_a = {24'd0, pix_q[{1'b0, pcnt_q}]};
        mul_b = {24'd0, pix_q[{1'b0, pcnt_q}]};
      end
      S_MUL0: begin
        mul_a = {11'd0, masked_q};
        mul_b = {13'd0, sq_q[ch_q][18:0]};
      end
      S_MUL1: begin
        mul_a = {11'd0, masked_q};
        mul_b = {14'd0, sq_q[ch_q][36:19]};
      end
      S_MUL2: begin
        mul_a = {3'd0, sum_q[{1'b0, ch_q}]};
        mul_b = {3'd0, sum_q[{1'b0, ch_q}]};
      end
      S_MUL3: begin
        mul_a = {11'd0, masked_q};
        mul_b = {11'd0, masked_q};
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // ratio operands for the current feature
  always_comb begin
    rnum     = '0;
    rden     = masked_q;
    is_ratio = 1'b1;
    case (feat_q)
      FEAT_AREA: begin
        rnum = {8'd0, masked_q};
        rden = total_q;
      end
      FEAT_H_MEAN: rnum = sum_q[0];
      FEAT_S_MEAN: rnum = sum_q[1];
      FEAT_V_MEAN: rnum = sum_q[2];
      FEAT_L_MEAN: rnum = sum_q[3];
      FEAT_A_MEAN: rnum = sum_q[4];
      FEAT_B_MEAN: rnum = sum_q[5];
      FEAT_BAND0:  rnum = {8'd0, band_q[0]};
      FEAT_BAND1:  rnum = {8'd0, band_q[1]};
      default:     is_ratio = 1'b0;
    endcase
  end

  assign div_req.start    = (state_q == S_FEAT && masked_q != '0 && is_ratio) ||
                            (state_q == S_MUL4);
  assign div_req.dividend = (state_q == S_MUL4) ? {num_q, 32'd0} : {45'd0, rnum, 16'd0};
  assign div_req.divisor  = (state_q == S_MUL4) ? mul_q[DIV_DSR_W-1:0] : {20'd0, rden};

  assign sq_req.start    = (state_q == S_DIV) && div_sts.done && std_q;
  assign sq_req.radicand = div_quo;

  // histogram port usage
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sw_q;
    ram_wdata = '0;
    ram_raddr = bin_in;
    case (state_q)
      S_CLR: ram_we = 1'b1;
      S_SWEEP: begin
        ram_raddr = sw_q;
        ram_we    = (sw_q != '0);
        ram_waddr = sw_q - 1'b1;
      end
      S_PIX: begin
        ram_we    = acc_q && (pcnt_q == 2'd0);
        ram_waddr = bin_q;
        ram_wdata = ram_rdata + 1'b1;
      end
      default: ;
    endcase
  end

  mcrs_ram #(.WIDTH(CNT_W), .DEPTH(HUE_BINS)) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mcrs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .sts_o      (div_sts),
    .quotient_o (div_quo)
  );

  mcrs_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sq_req),
    .sts_o  (sq_sts),
    .root_o (sq_root)
  );

  // payload registers
  always_ff @(posedge clk_i) begin
    mul_q <= mul_p;
    if (accept) begin
      pix_q[0] <= pix_i.hue;
      pix_q[1] <= pix_i.saturation;
      pix_q[2] <= pix_i.brightness;
      pix_q[3] <= pix_i.lightness;
      pix_q[4] <= pix_i.green_red;
      pix_q[5] <= pix_i.blue_yellow;
      bin_q    <= bin_in;
    end
    case (state_q)
      S_MUL1: acc_sum_q <= mul_q[ACC_W-1:0];
      S_MUL2: acc_sum_q <= acc_sum_q + {mul_q[38:0], 19'd0};
      S_MUL3: num_q <= (acc_sum_q > mul_q[ACC_W-1:0]) ? acc_sum_q - mul_q[ACC_W-1:0] : '0;
      default: ;
    endcase
  end

  // sequencer and frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      total_q     <= '0;
      masked_q    <= '0;
      for (int i = 0; i < 6; i++) sum_q[i] <= '0;
      for (int i = 0; i < 3; i++) sq_q[i] <= '0;
      band_q[0]   <= '0;
      band_q[1]   <= '0;
      acc_q       <= 1'b0;
      last_q      <= 1'b0;
      pcnt_q      <= '0;
      ch_q        <= '0;
      sw_q        <= '0;
      best_idx_q  <= '0;
      best_cnt_q  <= '0;
      feat_q      <= '0;
      std_q       <= 1'b0;
      val_q       <= '0;
      mean_s_q    <= '0;
      mean_v_q    <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_idx_q   <= '0;
      out_val_q   <= '0;
    end else begin
      // in S_EMIT the slot is either refilled below or still held
      if (out_valid_q && res_o.ready && state_q != S_EMIT) out_valid_q <= 1'b0;
      case (state_q)
        S_CLR: begin
          if (sw_q == HIST_AW'(HUE_BINS - 1)) begin
            sw_q    <= '0;
            state_q <= S_IDLE;
          end else begin
            sw_q <= sw_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            acc_q  <= under_lim && pix_i.in_mask;
            last_q <= pix_i.last_pixel;
            pcnt_q <= '0;
            if (under_lim) begin
              total_q <= total_q + 1'b1;
              if (pix_i.in_mask) begin
                masked_q <= masked_q + 1'b1;
                sum_q[0] <= sum_q[0] + SUM_W'(pix_i.hue);
                sum_q[1] <= sum_q[1] + SUM_W'(pix_i.saturation);
                sum_q[2] <= sum_q[2] + SUM_W'(pix_i.brightness);
                sum_q[3] <= sum_q[3] + SUM_W'(pix_i.lightness);
                sum_q[4] <= sum_q[4] + SUM_W'(pix_i.green_red);
                sum_q[5] <= sum_q[5] + SUM_W'(pix_i.blue_yellow);
                if (pix_i.hue >= brown_lo_q && pix_i.hue <= brown_hi_q)
                  band_q[0] <= band_q[0] + 1'b1;
                if (pix_i.hue >= golden_lo_q && pix_i.hue <= golden_hi_q)
                  band_q[1] <= band_q[1] + 1'b1;
              end
            end
            if ((under_lim && pix_i.in_mask) || pix_i.last_pixel) state_q <= S_PIX;
          end
        end
        S_PIX: begin
          if (acc_q) sq_q[pcnt_q] <= sq_q[pcnt_q] + SQ_W'(mul_p[15:0]);
          pcnt_q <= pcnt_q + 1'b1;
          if (pcnt_q == 2'd2) begin
            if (last_q) begin
              sw_q       <= '0;
              best_idx_q <= '0;
              best_cnt_q <= '0;
              state_q    <= S_SWEEP;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_SWEEP: begin
          // read data belongs to bin sw_q-1
          if (sw_q != '0 && ram_rdata > best_cnt_q) begin
            best_cnt_q <= ram_rdata;
            best_idx_q <= sw_q - 1'b1;
          end
          if (sw_q == HIST_AW'(HUE_BINS)) begin
            sw_q    <= '0;
            feat_q  <= FEAT_AREA;
            state_q <= S_FEAT;
          end else begin
            sw_q <= sw_q + 1'b1;
          end
        end
        S_FEAT: begin
          std_q <= (feat_q == FEAT_H_STD) || (feat_q == FEAT_S_STD) ||
                   (feat_q == FEAT_V_STD);
          if (masked_q == '0) begin
            val_q   <= '0;
            state_q <= S_EMIT;
          end else if (is_ratio) begin
            state_q <= S_DIV;
          end else begin
            case (feat_q)
              FEAT_H_STD: begin
                ch_q <= 2'd0; state_q <= S_MUL0;
              end
              FEAT_S_STD: begin
                ch_q <= 2'd1; state_q <= S_MUL0;
              end
              FEAT_V_STD: begin
                ch_q <= 2'd2; state_q <= S_MUL0;
              end
              FEAT_DOM_HUE: begin
                val_q <= {best_idx_q, 16'd0}; state_q <= S_EMIT;
              end
              FEAT_S_AGAIN: begin
                val_q <= mean_s_q; state_q <= S_EMIT;
              end
              FEAT_V_AGAIN: begin
                val_q <= mean_v_q; state_q <= S_EMIT;
              end
              default: begin
                val_q <= '0; state_q <= S_EMIT;
              end
            endcase
          end
        end
        S_MUL0: state_q <= S_MUL1;
        S_MUL1: state_q <= S_MUL2;
        S_MUL2: state_q <= S_MUL3;
        S_MUL3: state_q <= S_MUL4;
        S_MUL4: state_q <= S_DIV;
        S_DIV: begin
          if (div_sts.done) begin
            if (std_q) begin
              state_q <= S_SQRT;
            end else begin
              val_q   <= div_quo[FVAL_W-1:0];
              state_q <= S_EMIT;
            end
          end
        end
        S_SQRT: begin
          if (sq_sts.done) begin
            val_q   <= sq_root;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= feat_q;
            out_val_q   <= val_q;
            out_last_q  <= (feat_q == FEAT_BAND1);
            if (feat_q == FEAT_S_MEAN) mean_s_q <= val_q;
            if (feat_q == FEAT_V_MEAN) mean_v_q <= val_q;
            if (feat_q == FEAT_BAND1) begin
              total_q  <= '0;
              masked_q <= '0;
              for (int i = 0; i < 6; i++) sum_q[i] <= '0;
              for (int i = 0; i < 3; i++) sq_q[i] <= '0;
              band_q[0] <= '0;
              band_q[1] <= '0;
              state_q   <= S_IDLE;
            end else begin
              feat_q  <= feat_q + 1'b1;
              state_q <= S_FEAT;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.feature_index = out_idx_q;
  assign res_o.feature_value = out_val_q;
  assign res_o.last_feature  = out_last_q;

  a_masked_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    masked_q <= total_q)
    else $error("masked count exceeds pixel total");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> state_q == S_DIV)
    else $error("divider finished outside its wait state");

  a_frame_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && slot_free && feat_q == FEAT_BAND1)
      |=> (total_q == '0 && masked_q == '0 && state_q == S_IDLE))
    else $error("frame state not cleared after report");

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_sts.busy && sq_sts.busy))
    else $error("divider and square root active together");

endmodule
